### rtl/lru_pr_pkg.sv
// lru_pr_pkg: shared types and constants for the LRU page replacement block.
// No dependencies; imported by lru_page_replacement_top.
package lru_pr_pkg;

    // Fixed field widths
    localparam int CFG_W       = 5;
    localparam int FRAME_IDX_W = 4;
    localparam int FAULT_W     = 32;
    localparam int TUSER_W     = 2;

    // Sequencer state
    typedef logic [2:0] t_state;

    localparam t_state ST_IDLE   = 3'd0;
    localparam t_state ST_SCAN   = 3'd1;
    localparam t_state ST_DECIDE = 3'd2;
    localparam t_state ST_UPD    = 3'd3;
    localparam t_state ST_FIN    = 3'd4;

endpackage

### rtl/lru_page_replacement_top.sv
// lru_page_replacement_top: fully associative page-frame set with LRU replacement.
// Depends on lru_pr_pkg (state codes, field widths).
//
// One page reference per request on the slave stream; one result per reference on
// the master stream. A hit refreshes the frame's recency, a miss fills the lowest
// free frame while fewer than frames_in_use frames are held (0 acts as 1, values
// above MAX_FRAMES act as MAX_FRAMES), else it replaces the least recently used
// frame. A single sequencer walks the frames through one page/rank memory read
// port: a scan pass (match compare and max-rank search, one frame a cycle), a
// decision state, and an update pass that rewrites each used frame's rank. A
// new reference is not taken until the previous one has its result; the slave
// side is ready again in the cycle the result appears. The result sits in an
// output register, so the next reference is taken while it waits; that
// reference holds in its final state until the output register is free.
// frames_in_use is written through the cfg channel, which is always ready; write
// it only while no reference is in flight. No clearing pass is needed after reset.

module lru_page_replacement_top
    import lru_pr_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration write: frames_in_use
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,

    // Reference requests
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata, low bit up: page[PAGE_BITS], zero pad to whole bytes
    input  logic [((PAGE_BITS+7)/8)*8-1:0] i_s_tdata,

    // Results
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata, low bit up: frame_index[4], evicted_page[PAGE_BITS], fault_count[32], pad
    output logic [((FRAME_IDX_W+PAGE_BITS+FAULT_W+7)/8)*8-1:0] o_m_tdata,
    // tuser, low bit up: hit, evicted
    output logic [TUSER_W-1:0]     o_m_tuser
);

    localparam int IDXW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNTW    = $clog2(MAX_FRAMES + 1);
    localparam int LW      = (CNTW > CFG_W) ? CNTW : CFG_W;
    localparam int OUT_RAW = FRAME_IDX_W + PAGE_BITS + FAULT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_FRAMES - 1);
    localparam logic [CNTW-1:0] N_FRAMES = CNTW'(MAX_FRAMES);
    localparam logic [LW-1:0]   LIM_MAX  = LW'(MAX_FRAMES);

    // Frame memories: page and recency rank per frame.
    // Entries at or above the fill count are never used, so no reset.
    logic [PAGE_BITS-1:0] mem_pg [MAX_FRAMES];
    logic [IDXW-1:0]      mem_rk [MAX_FRAMES];

    logic [PAGE_BITS-1:0] r_pg_q;
    logic [IDXW-1:0]      r_rk_q;

    // Control state
    t_state               r_state,   n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [CNTW-1:0]      r_occ,     n_occ;
    logic [FAULT_W-1:0]   r_faults,  n_faults;
    logic [CNTW-1:0]      r_cnt,     n_cnt;
    logic                 r_p_vld,   n_p_vld;
    logic                 r_out_vld, n_out_vld;

    // Payload / working registers
    logic [IDXW-1:0]      r_p_idx,   n_p_idx;
    logic [PAGE_BITS-1:0] r_page,    n_page;
    logic                 r_hit,     n_hit;
    logic [IDXW-1:0]      r_hit_f,   n_hit_f;
    logic [IDXW-1:0]      r_hit_rk,  n_hit_rk;
    logic                 r_found,   n_found;
    logic [IDXW-1:0]      r_best,    n_best;
    logic [IDXW-1:0]      r_lru_f,   n_lru_f;
    logic [PAGE_BITS-1:0] r_lru_pg,  n_lru_pg;
    logic [IDXW-1:0]      r_f,       n_f;
    logic [CNTW-1:0]      r_old,     n_old;
    logic                 r_res_ev,  n_res_ev;
    logic [PAGE_BITS-1:0] r_res_pg,  n_res_pg;
    logic                 r_o_hit,   n_o_hit;
    logic                 r_o_ev,    n_o_ev;
    logic [FRAME_IDX_W-1:0] r_o_f,   n_o_f;
    logic [PAGE_BITS-1:0] r_o_pg,    n_o_pg;
    logic [FAULT_W-1:0]   r_o_flt,   n_o_flt;

    // Memory port controls
    logic                 pg_we;
    logic [IDXW-1:0]      pg_waddr;
    logic                 rk_we;
    logic [IDXW-1:0]      rk_wdata;
    logic [IDXW-1:0]      rd_addr;

    // Helpers
    logic                 in_acc;
    logic                 out_take;
    logic                 issue;
    logic                 p_valid_frame;
    logic [LW-1:0]        lim;
    logic [LW-1:0]        cfg_ext;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_take    = r_out_vld && i_m_tready;
    assign issue       = (r_cnt < N_FRAMES);
    assign rd_addr     = r_cnt[IDXW-1:0];
    // Frames fill lowest first and are never freed: valid == below fill count
    assign p_valid_frame = (CNTW'(r_p_idx) < r_occ);

    // Clamp the configured limit to 1..MAX_FRAMES
    assign cfg_ext = LW'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            lim = LW'(1);
        end else if (cfg_ext > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = cfg_ext;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_faults  = r_faults;
        n_cnt     = r_cnt;
        n_p_vld   = 1'b0;
        n_p_idx   = r_p_idx;
        n_page    = r_page;
        n_hit     = r_hit;
        n_hit_f   = r_hit_f;
        n_hit_rk  = r_hit_rk;
        n_found   = r_found;
        n_best    = r_best;
        n_lru_f   = r_lru_f;
        n_lru_pg  = r_lru_pg;
        n_f       = r_f;
        n_old     = r_old;
        n_res_ev  = r_res_ev;
        n_res_pg  = r_res_pg;
        n_o_hit   = r_o_hit;
        n_o_ev    = r_o_ev;
        n_o_f     = r_o_f;
        n_o_pg    = r_o_pg;
        n_o_flt   = r_o_flt;
        n_out_vld = out_take ? 1'b0 : r_out_vld;
        pg_we     = 1'b0;
        pg_waddr  = r_f;
        rk_we     = 1'b0;
        rk_wdata  = r_rk_q;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_page  = i_s_tdata[PAGE_BITS-1:0];
                    n_hit   = 1'b0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // issue one read a cycle, evaluate the frame read last cycle
                if (issue) begin
                    n_cnt   = r_cnt + CNTW'(1);
                    n_p_vld = 1'b1;
                    n_p_idx = r_cnt[IDXW-1:0];
                end
                if (r_p_vld && p_valid_frame) begin
                    if (!r_hit && (r_pg_q == r_page)) begin
                        n_hit    = 1'b1;
                        n_hit_f  = r_p_idx;
                        n_hit_rk = r_rk_q;
                    end
                    if (!r_found || (r_rk_q > r_best)) begin
                        n_found  = 1'b1;
                        n_best   = r_rk_q;
                        n_lru_f  = r_p_idx;
                        n_lru_pg = r_pg_q;
                    end
                end
                if (r_p_vld && (r_p_idx == LAST_IDX)) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_res_ev = 1'b0;
                n_res_pg = '0;
                if (r_hit) begin
                    n_f   = r_hit_f;
                    n_old = CNTW'(r_hit_rk);
                end else begin
                    if (r_faults != '1) begin
                        n_faults = r_faults + FAULT_W'(1);
                    end
                    pg_we = 1'b1;
                    if (LW'(r_occ) < lim) begin
                        // fill: every resident frame ages
                        n_f      = r_occ[IDXW-1:0];
                        n_old    = N_FRAMES;
                        n_occ    = r_occ + CNTW'(1);
                        pg_waddr = r_occ[IDXW-1:0];
                    end else begin
                        n_f      = r_lru_f;
                        n_old    = CNTW'(r_best);
                        n_res_ev = 1'b1;
                        n_res_pg = r_lru_pg;
                        pg_waddr = r_lru_f;
                    end
                end
                n_cnt   = '0;
                n_state = ST_UPD;
            end

            ST_UPD: begin
                // read-modify-write of each rank, one frame a cycle
                if (issue) begin
                    n_cnt   = r_cnt + CNTW'(1);
                    n_p_vld = 1'b1;
                    n_p_idx = r_cnt[IDXW-1:0];
                end
                if (r_p_vld && p_valid_frame) begin
                    rk_we = 1'b1;
                    if (r_p_idx == r_f) begin
                        rk_wdata = '0;
                    end else if (CNTW'(r_rk_q) < r_old) begin
                        rk_wdata = r_rk_q + IDXW'(1);
                    end
                end
                if (r_p_vld && (r_p_idx == LAST_IDX)) begin
                    n_state = ST_FIN;
                end
            end

            ST_FIN: begin
                if (!r_out_vld || i_m_tready) begin
                    n_o_hit   = r_hit;
                    n_o_ev    = r_res_ev;
                    n_o_f     = FRAME_IDX_W'(r_f);
                    n_o_pg    = r_res_pg;
                    n_o_flt   = r_faults;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Frame memories: one write port each, registered read at the scan address
    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            mem_pg[pg_waddr] <= r_page;
        end
        if (rk_we) begin
            mem_rk[r_p_idx] <= rk_wdata;
        end
        r_pg_q <= mem_pg[rd_addr];
        r_rk_q <= mem_rk[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= CFG_W'(16);
            r_occ     <= '0;
            r_faults  <= '0;
            r_cnt     <= '0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_faults  <= n_faults;
            r_cnt     <= n_cnt;
            r_p_vld   <= n_p_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p_idx  <= n_p_idx;
        r_page   <= n_page;
        r_hit    <= n_hit;
        r_hit_f  <= n_hit_f;
        r_hit_rk <= n_hit_rk;
        r_found  <= n_found;
        r_best   <= n_best;
        r_lru_f  <= n_lru_f;
        r_lru_pg <= n_lru_pg;
        r_f      <= n_f;
        r_old    <= n_old;
        r_res_ev <= n_res_ev;
        r_res_pg <= n_res_pg;
        r_o_hit  <= n_o_hit;
        r_o_ev   <= n_o_ev;
        r_o_f    <= n_o_f;
        r_o_pg   <= n_o_pg;
        r_o_flt  <= n_o_flt;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = {r_o_ev, r_o_hit};
    assign o_m_tdata  = OUT_W'({r_o_flt, r_o_pg, r_o_f});

endmodule
